// ===== src/r2e_pkg.sv =====
package r2e_pkg;

    // CORDIC vector and angle accumulator widths
    localparam int CW = 28;
    localparam int AW = 30;
    // Square-root radicand, root register and final root widths
    localparam int RW = 49;
    localparam int SW = 50;
    localparam int QW = 25;
    localparam int SQ_CELLS = 25;
    localparam int OW = 17;
    localparam int TAB_LEN = 24;

    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
    localparam logic signed [17:0] LIM_XZ = 18'sd23040;
    localparam logic signed [17:0] LIM_Y = 18'sd11520;
    localparam logic signed [AW-1:0] DEG90 = 30'sd94371840;
    localparam logic signed [AW-1:0] ROUND_HALF = 30'sd4096;
    localparam int OUT_SHIFT = 13;

    // atan(2^-i) in degrees * 2^20
    localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058, 30'sd1876857, 30'sd938658, 30'sd469357,
        30'sd234682, 30'sd117342, 30'sd58671, 30'sd29335,
        30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
        30'sd917, 30'sd458, 30'sd229, 30'sd115,
        30'sd57, 30'sd29, 30'sd14, 30'sd7
    };

    typedef enum logic [1:0] {
        CASE_NORMAL = 2'd0,
        CASE_NEG    = 2'd1,
        CASE_POS    = 2'd2
    } case_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic [RW-1:0] v;
        logic [SW-1:0] res;
    } sqrt_t;

    typedef struct packed {
        logic signed [17:0] xa;
        logic signed [17:0] xb;
        logic signed [17:0] za;
        logic signed [17:0] zb;
        logic signed [17:0] r20;
        case_t              code;
    } side_t;

    function automatic logic signed [17:0] sat_unit(logic signed [17:0] v);
        logic signed [17:0] r;
        r = v;
        if (v > ONE_Q16)
        begin
            r = ONE_Q16;
        end
        else if (v < -ONE_Q16)
        begin
            r = -ONE_Q16;
        end
        return r;
    endfunction

    function automatic logic signed [17:0] clamp(logic signed [17:0] v,
                                                 logic signed [17:0] lim);
        logic signed [17:0] r;
        r = v;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] scale_q(logic signed [17:0] v);
        return {{(CW-26){v[17]}}, v, 8'd0};
    endfunction

endpackage

// ===== src/r2e_if.sv =====
interface r2e_in_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] r00;
    logic signed [17:0] r10;
    logic signed [17:0] r11;
    logic signed [17:0] r12;
    logic signed [17:0] r20;
    logic signed [17:0] r21;
    logic signed [17:0] r22;

    modport source (output valid, r00, r10, r11, r12, r20, r21, r22, input ready);
    modport sink (input valid, r00, r10, r11, r12, r20, r21, r22, output ready);
endinterface

interface r2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x_deg;
    logic signed [14:0] angle_y_deg;
    logic signed [15:0] angle_z_deg;
    logic [1:0]         case_code;

    modport source (output valid, angle_x_deg, angle_y_deg, angle_z_deg, case_code,
                    input ready);
    modport sink (input valid, angle_x_deg, angle_y_deg, angle_z_deg, case_code,
                  output ready);
endinterface

// ===== src/rotation_matrix_to_euler_zyx_unit.sv =====
// Z-Y-X Euler angles from a rotation matrix. Each item carries seven Q1.16
// elements; the result gives the three angles in 1/128 degree and a case
// code (normal, r20 at or below -1, r20 at or above +1; in the latter two
// x is zero and y is +90 or -90). The unit is a straight pipeline: an input
// stage with the r20 squaring multiplier, a radicand stage, a row of 25
// square-root cells (one root bit each), a quarter-turn stage, a row of
// CORDIC_STAGES CORDIC cells running three angle lanes side by side, and an
// output register. It takes one item every cycle while the output is not
// held; the pipeline holds CORDIC_STAGES + 29 register stages.
// When the output is held by the sink the whole pipeline halts in place.
module rotation_matrix_to_euler_zyx_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input logic          clk,
    input logic          rst_n,
    r2e_in_if.sink       in_ch,
    r2e_out_if.source    out_ch
);
    import r2e_pkg::*;

    localparam int DEPTH = SQ_CELLS + CORDIC_STAGES + 4;

    logic                 adv;
    logic                 in_acc;
    logic [DEPTH-1:0]     vld_reg;
    logic [DEPTH-1:0]     vld_next;

    logic signed [17:0]   r00s, r10s, r11s, r12s, r20s, r21s, r22s;
    logic signed [35:0]   prod;
    side_t                side0_next;
    side_t                side0_reg;
    logic [32:0]          sq_reg;
    side_t                side1_reg;
    logic [RW-1:0]        rad_reg;
    logic [32:0]          rem;

    sqrt_t                sq_bus [SQ_CELLS+1];
    side_t                side_line_reg [SQ_CELLS];
    side_t                side_q;
    logic [QW-1:0]        root;

    cordic_t              cx_bus [CORDIC_STAGES+1];
    cordic_t              cy_bus [CORDIC_STAGES+1];
    cordic_t              cz_bus [CORDIC_STAGES+1];
    case_t                code_line_reg [CORDIC_STAGES+1];
    case_t                code_q;

    logic signed [AW-1:0] rx, ry, rz;
    logic signed [17:0]   tx, ty, tz;
    logic signed [15:0]   ax_next, az_next;
    logic signed [14:0]   ay_next;
    logic signed [15:0]   ax_reg, az_reg;
    logic signed [14:0]   ay_reg;
    case_t                code_reg;

    // Advance everything unless a finished item is still held at the output
    assign adv         = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign in_acc      = in_ch.valid && adv;
    assign vld_next    = {vld_reg[DEPTH-2:0], in_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Saturate elements, pick the case and the operands of each lane
    always_comb
    begin
        r00s = sat_unit(in_ch.r00);
        r10s = sat_unit(in_ch.r10);
        r11s = sat_unit(in_ch.r11);
        r12s = sat_unit(in_ch.r12);
        r20s = sat_unit(in_ch.r20);
        r21s = sat_unit(in_ch.r21);
        r22s = sat_unit(in_ch.r22);
        prod = r20s * r20s;
        priority if (r20s <= -ONE_Q16)
        begin
            side0_next.code = CASE_NEG;
        end
        else if (r20s >= ONE_Q16)
        begin
            side0_next.code = CASE_POS;
        end
        else
        begin
            side0_next.code = CASE_NORMAL;
        end
        side0_next.xa  = r21s;
        side0_next.xb  = r22s;
        side0_next.r20 = r20s;
        if (side0_next.code == CASE_NORMAL)
        begin
            side0_next.za = r10s;
            side0_next.zb = r00s;
        end
        else
        begin
            side0_next.za = r12s;
            side0_next.zb = r11s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side0_reg <= side0_next;
            sq_reg    <= prod[32:0];
        end
    end

    // Form the radicand (1 - r20^2) scaled for a Q.24 root
    assign rem = 33'h1_0000_0000 - sq_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side0_reg;
            rad_reg   <= {rem, 16'd0};
        end
    end

    // Square-root row, side data delayed alongside
    assign sq_bus[0] = '{v: rad_reg, res: '0};

    for (genvar k = 0; k < SQ_CELLS; k++)
    begin : g_sqrt
        r2e_sqrt_cell #(.K(k)) u_cell (
            .clk (clk),
            .en  (adv),
            .d   (sq_bus[k]),
            .q   (sq_bus[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_line_reg[k] <= (k == 0) ? side1_reg : side_line_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign side_q = side_line_reg[SQ_CELLS-1];
    assign root   = sq_bus[SQ_CELLS].res[QW-1:0];

    // Quarter-turn stage for the three lanes
    r2e_cordic_pre u_pre_x (
        .clk (clk),
        .en  (adv),
        .y   (scale_q(side_q.xa)),
        .x   (scale_q(side_q.xb)),
        .q   (cx_bus[0])
    );

    r2e_cordic_pre u_pre_y (
        .clk (clk),
        .en  (adv),
        .y   (scale_q(side_q.r20)),
        .x   ({{(CW-QW){1'b0}}, root}),
        .q   (cy_bus[0])
    );

    r2e_cordic_pre u_pre_z (
        .clk (clk),
        .en  (adv),
        .y   (scale_q(side_q.za)),
        .x   (scale_q(side_q.zb)),
        .q   (cz_bus[0])
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_line_reg[0] <= side_q.code;
        end
    end

    // CORDIC row, three lanes per stage
    for (genvar j = 0; j < CORDIC_STAGES; j++)
    begin : g_cordic
        r2e_cordic_cell #(.I(j)) u_cx (
            .clk (clk),
            .en  (adv),
            .d   (cx_bus[j]),
            .q   (cx_bus[j+1])
        );

        r2e_cordic_cell #(.I(j)) u_cy (
            .clk (clk),
            .en  (adv),
            .d   (cy_bus[j]),
            .q   (cy_bus[j+1])
        );

        r2e_cordic_cell #(.I(j)) u_cz (
            .clk (clk),
            .en  (adv),
            .d   (cz_bus[j]),
            .q   (cz_bus[j+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                code_line_reg[j+1] <= code_line_reg[j];
            end
        end
    end

    assign code_q = code_line_reg[CORDIC_STAGES];

    // Round to 1/128 degree, apply case rules and clamp
    always_comb
    begin
        rx = cx_bus[CORDIC_STAGES].zero ? '0 : cx_bus[CORDIC_STAGES].z + ROUND_HALF;
        ry = cy_bus[CORDIC_STAGES].zero ? '0 : cy_bus[CORDIC_STAGES].z + ROUND_HALF;
        rz = cz_bus[CORDIC_STAGES].zero ? '0 : cz_bus[CORDIC_STAGES].z + ROUND_HALF;
        tx = {rx[AW-1], rx[AW-1:OUT_SHIFT]};
        ty = {ry[AW-1], ry[AW-1:OUT_SHIFT]};
        tz = {rz[AW-1], rz[AW-1:OUT_SHIFT]};
        unique case (code_q)
            CASE_NORMAL:
            begin
                ax_next = 16'(clamp(tx, LIM_XZ));
                ay_next = 15'(clamp(-ty, LIM_Y));
                az_next = 16'(clamp(tz, LIM_XZ));
            end
            CASE_NEG:
            begin
                ax_next = '0;
                ay_next = 15'(LIM_Y);
                az_next = 16'(clamp(-tz, LIM_XZ));
            end
            default:
            begin
                ax_next = '0;
                ay_next = 15'(-LIM_Y);
                az_next = 16'(clamp(-tz, LIM_XZ));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            az_reg   <= az_next;
            code_reg <= code_q;
        end
    end

    assign out_ch.valid       = vld_reg[DEPTH-1];
    assign out_ch.angle_x_deg = ax_reg;
    assign out_ch.angle_y_deg = ay_reg;
    assign out_ch.angle_z_deg = az_reg;
    assign out_ch.case_code   = 2'(code_reg);

endmodule

// ===== src/r2e_sqrt_cell.sv =====
module r2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic           clk,
    input  logic           en,
    input  r2e_pkg::sqrt_t d,
    output r2e_pkg::sqrt_t q
);
    import r2e_pkg::*;

    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ_CELLS - 1 - K));

    sqrt_t         q_reg;
    sqrt_t         q_next;
    logic [SW-1:0] trial;

    // Try one root bit: subtract when the remainder allows it
    always_comb
    begin
        trial = d.res + BIT;
        if ({1'b0, d.v} >= trial)
        begin
            q_next.v   = RW'({1'b0, d.v} - trial);
            q_next.res = (d.res >> 1) + BIT;
        end
        else
        begin
            q_next.v   = d.v;
            q_next.res = d.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== src/r2e_cordic_pre.sv =====
module r2e_cordic_pre (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [r2e_pkg::CW-1:0] y,
    input  logic signed [r2e_pkg::CW-1:0] x,
    output r2e_pkg::cordic_t            q
);
    import r2e_pkg::*;

    cordic_t q_reg;
    cordic_t q_next;

    // Fold the left half-plane into the right one with a quarter turn
    always_comb
    begin
        q_next.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            if (y >= 0)
            begin
                q_next.x = y;
                q_next.y = -x;
                q_next.z = DEG90;
            end
            else
            begin
                q_next.x = -y;
                q_next.y = x;
                q_next.z = -DEG90;
            end
        end
        else
        begin
            q_next.x = x;
            q_next.y = y;
            q_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== src/r2e_cordic_cell.sv =====
module r2e_cordic_cell #(
    parameter int I = 0
) (
    input  logic             clk,
    input  logic             en,
    input  r2e_pkg::cordic_t d,
    output r2e_pkg::cordic_t q
);
    import r2e_pkg::*;

    cordic_t              q_reg;
    cordic_t              q_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    // Rotate toward the x axis by one micro-angle
    always_comb
    begin
        xs = $signed(d.x) >>> I;
        ys = $signed(d.y) >>> I;
        q_next.zero = d.zero;
        if (d.y >= 0)
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + ATAN_TAB[I];
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - ATAN_TAB[I];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
